FILE: rtl/core/merge_sort_buffer_top_assert.svh
// Assertion macros for the merge sort buffer.
`ifndef MERGE_SORT_BUFFER_TOP_ASSERT_SVH
`define MERGE_SORT_BUFFER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define MSB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MSB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MSB_ASSERT(label, clk, rst_n, prop, msg)
`define MSB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/core/msb_pkg.sv
// Package for the merge sort buffer: payload types and constants.
package msb_pkg;
    localparam int DEPTH_DEF = 64;
    localparam int DATA_W = 32;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } msb_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value_res;
        logic                     last_res;
        logic                     overflow;
    } msb_out_t;

    // Front-to-back queue entry
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     keep;
        logic                     fin;
    } msb_cmd_t;
endpackage

FILE: rtl/core/merge_sort_buffer_top.sv
// Top level of the merge sort buffer.
// Usage:
//   Input channel (in_valid/in_stall/in_data) takes one signed element per
//   transaction; last marks the end of a list. Up to DEPTH elements are kept,
//   later ones are dropped and flag overflow on every result of that list.
//   After the last element the back end runs log2(n) bottom-up merge passes
//   over a ping-pong memory pair (S_RD then S_MERGE per merged element),
//   then emits the sorted list on the output channel (out_valid/out_stall/
//   out_data), S_EMIT_RD then S_EMIT per element, last_res on the final one.
//   A two-entry queue separates input from the sorter, so the front keeps
//   accepting while the back sorts until the queue fills.
//   Reset clears counters and control; memory contents are not cleared.
//   A stalled output holds its transaction; the sorter waits meanwhile.
module merge_sort_buffer_top
    import msb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  msb_in_t  in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output msb_out_t out_data
);
    logic     q_valid, q_pop;
    msb_cmd_t q_data;

    msb_front #(.DEPTH(DEPTH)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
    );

    msb_back #(.DEPTH(DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );
endmodule

FILE: rtl/core/msb_front.sv
// Front end: accepts elements, classifies keep/drop, queues them for the sorter.
module msb_front
    import msb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  msb_in_t  in_data,
    output logic     q_valid,
    input  logic     q_pop,
    output msb_cmd_t q_data
);
    localparam int CW = $clog2(DEPTH + 1);

    msb_cmd_t       fifo_reg [2];
    logic [1:0]     cnt_reg, cnt_next;
    logic           wp_reg, rp_reg;
    logic [CW-1:0]  kept_reg, kept_next;
    logic           push;
    msb_cmd_t       cmd;

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = fifo_reg[rp_reg];

    always_comb
    begin
        cmd.value = in_data.value;
        cmd.keep  = (kept_reg < CW'(DEPTH));
        cmd.fin   = in_data.last;
        kept_next = kept_reg;
        if (push)
        begin
            if (in_data.last)
                kept_next = '0;
            else if (cmd.keep)
                kept_next = kept_reg + 1'b1;
        end
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop && q_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
            kept_reg <= '0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            kept_reg <= kept_next;
            if (push)
                wp_reg <= ~wp_reg;
            if (q_pop && q_valid)
                rp_reg <= ~rp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wp_reg] <= cmd;
    end
endmodule

FILE: rtl/core/msb_back.sv
// Back end: stores elements, runs the bottom-up merge passes, emits the sorted list.
`include "merge_sort_buffer_top_assert.svh"
module msb_back
    import msb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     q_valid,
    output logic     q_pop,
    input  msb_cmd_t q_data,
    output logic     out_valid,
    input  logic     out_stall,
    output msb_out_t out_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = CW + 1;

    typedef enum logic [2:0] {
        S_LOAD, S_PASS, S_RD, S_MERGE, S_EMIT_RD, S_EMIT
    } state_t;

    logic [DATA_W-1:0] mem_a [DEPTH];
    logic [DATA_W-1:0] mem_b [DEPTH];

    state_t         state_reg;
    logic [CW-1:0]  n_reg;
    logic           drop_reg;
    logic           side_reg;    // 0: source is mem_a
    logic [WW-1:0]  width_reg;
    logic [WW:0]    lo_reg, a_reg, b_reg, mid_reg, hi_reg, k_reg;
    logic [DATA_W-1:0] rda_reg, rdb_reg;
    logic           out_valid_reg;
    msb_out_t       out_reg;
    logic           a_ok, b_ok, take_a;
    logic [WW:0]    mid_c, hi_c, n_ext;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic           k_ok;

    assign n_ext = (WW+1)'(n_reg);
    assign mid_c = ((lo_reg + (WW+1)'(width_reg)) > n_ext) ? n_ext
                 : lo_reg + (WW+1)'(width_reg);
    assign hi_c  = ((lo_reg + (WW+1)'({width_reg, 1'b0})) > n_ext) ? n_ext
                 : lo_reg + (WW+1)'({width_reg, 1'b0});
    assign a_ok   = a_reg < mid_reg;
    assign b_ok   = b_reg < hi_reg;
    assign take_a = a_ok && (!b_ok || ($signed(rda_reg) <= $signed(rdb_reg)));
    assign k_ok   = (state_reg != S_MERGE) || (k_reg == a_reg + b_reg - mid_reg);

    assign q_pop     = (state_reg == S_LOAD) && q_valid;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Memory reads: both read ports at a and b of the source side.
    always_ff @(posedge clk)
    begin
        rda_reg <= side_reg ? mem_b[a_reg[AW-1:0]] : mem_a[a_reg[AW-1:0]];
        rdb_reg <= side_reg ? mem_b[b_reg[AW-1:0]] : mem_a[b_reg[AW-1:0]];
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = k_reg[AW-1:0];
        wr_data = take_a ? rda_reg : rdb_reg;
        if (state_reg == S_LOAD && q_valid && q_data.keep)
        begin
            wr_en   = 1'b1;
            wr_addr = n_reg[AW-1:0];
            wr_data = q_data.value;
        end
        else if (state_reg == S_MERGE && k_reg < hi_reg)
            wr_en = 1'b1;
    end

    // Destination is the side opposite the source; loads go to mem_a.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            if (state_reg == S_LOAD || side_reg)
                mem_a[wr_addr] <= wr_data;
            else
                mem_b[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            n_reg         <= '0;
            drop_reg      <= 1'b0;
            side_reg      <= 1'b0;
            width_reg     <= '0;
            lo_reg        <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            mid_reg       <= '0;
            hi_reg        <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_LOAD:
                begin
                    if (q_valid)
                    begin
                        logic [CW-1:0] nn;
                        nn = q_data.keep ? n_reg + 1'b1 : n_reg;
                        n_reg <= nn;
                        if (!q_data.keep)
                            drop_reg <= 1'b1;
                        if (q_data.fin)
                        begin
                            side_reg  <= 1'b0;
                            width_reg <= WW'(1);
                            lo_reg    <= '0;
                            state_reg <= S_PASS;
                        end
                    end
                end
                S_PASS:
                begin
                    if ((WW+1)'(width_reg) >= n_ext)
                    begin
                        k_reg     <= '0;
                        a_reg     <= '0;
                        state_reg <= S_EMIT_RD;
                    end
                    else if (lo_reg >= n_ext)
                    begin
                        lo_reg    <= '0;
                        width_reg <= {width_reg[WW-2:0], 1'b0};
                        side_reg  <= ~side_reg;
                    end
                    else
                    begin
                        a_reg     <= lo_reg;
                        b_reg     <= mid_c;
                        k_reg     <= lo_reg;
                        mid_reg   <= mid_c;
                        hi_reg    <= hi_c;
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_MERGE;
                end
                S_MERGE:
                begin
                    // rda/rdb hold data at a/b from the prior read cycle
                    if (k_reg >= hi_reg)
                    begin
                        lo_reg    <= hi_reg;
                        state_reg <= S_PASS;
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                        if (take_a)
                            a_reg <= a_reg + 1'b1;
                        else
                            b_reg <= b_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                end
                S_EMIT_RD:
                begin
                    if (!out_valid_reg || !out_stall)
                        state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg      <= 1'b1;
                        out_reg.value_res  <= rda_reg;
                        out_reg.last_res   <= (k_reg + 1'b1 == n_ext);
                        out_reg.overflow   <= drop_reg;
                        if (k_reg + 1'b1 == n_ext)
                        begin
                            n_reg     <= '0;
                            drop_reg  <= 1'b0;
                            side_reg  <= 1'b0;
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 1'b1;
                            a_reg     <= a_reg + 1'b1;
                            state_reg <= S_EMIT_RD;
                        end
                    end
                end
                default:
                    state_reg <= S_LOAD;
            endcase
        end
    end

    `MSB_ASSERT(a_count_bound, clk, rst_n, (n_reg <= CW'(DEPTH)), "item count past depth")
    `MSB_ASSERT(a_merge_k, clk, rst_n, k_ok, "merge index mismatch")
    `MSB_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "output changed under stall")
endmodule
